// ===== hdl/lzssd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the LZSS decoder with an 8 KiB window.
// ----------------------------------------------------------------------------
package lzssd_pkg;

    localparam int WINDOW_DEPTH_DEF = 8192;

    localparam int OFS_W   = 13;                 // absolute offset field
    localparam int LEN_W   = 4;                  // length field
    localparam int TOK_W   = 1 + OFS_W + LEN_W;  // longest token
    localparam int CNT_W   = 5;                  // token bit count
    localparam int LIMIT_W = 30;
    localparam int RUN_W   = LEN_W + 1;          // copy length after bias

    localparam int LIT_BITS   = 9;               // flag + 8 data bits
    localparam int END_BITS   = 1 + OFS_W;       // flag + offset
    localparam int MATCH_BITS = TOK_W;

    localparam int LEN_BIAS   = 3;
    localparam int GUARD_BITS = 64;              // zero bits fed after a final byte
    localparam int GUARD_W    = 7;

    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = LIMIT_W'(32'h2000_0000);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BIT   = 5'b00010,
        ST_RD    = 5'b00100,
        ST_CPY   = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    typedef struct packed {
        logic             literal;
        logic             end_mark;
        logic             match;
        logic [7:0]       lit_val;
        logic [OFS_W-1:0] ofs;
        logic [RUN_W-1:0] len;
    } tok_evt_t;

endpackage
`default_nettype wire

// ===== hdl/lzssd_token.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzssd_token
// Token assembler: takes one stream bit per push and flags complete tokens.
// ----------------------------------------------------------------------------
module lzssd_token
    import lzssd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     clear,
    input  wire logic     push,
    input  wire logic     bit_in,
    output tok_evt_t      evt
);

    logic [TOK_W-1:0] bits_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             flag_reg;

    logic [TOK_W-1:0] shifted;
    logic [CNT_W-1:0] cnt_inc;
    logic             flag_now;

    // Flags tell what the offered bit would complete; they count only on push
    always_comb begin
        shifted  = {bits_reg[TOK_W-2:0], bit_in};
        cnt_inc  = cnt_reg + CNT_W'(1);
        flag_now = (cnt_reg == '0) ? bit_in : flag_reg;

        evt.literal  = flag_now && (cnt_inc == CNT_W'(LIT_BITS));
        evt.end_mark = !flag_now && (cnt_inc == CNT_W'(END_BITS))
                       && (shifted[OFS_W-1:0] == '0);
        evt.match    = !flag_now && (cnt_inc == CNT_W'(MATCH_BITS));
        evt.lit_val  = shifted[7:0];
        evt.ofs      = shifted[LEN_W +: OFS_W];
        evt.len      = {1'b0, shifted[LEN_W-1:0]} + RUN_W'(LEN_BIAS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            bits_reg <= '0;
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end else if (push) begin
            if (evt.literal || evt.match) begin
                bits_reg <= '0;
                cnt_reg  <= '0;
                flag_reg <= 1'b0;
            end else begin
                bits_reg <= shifted;
                cnt_reg  <= cnt_inc;
                flag_reg <= flag_now;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lzssd_dict.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzssd_dict
// History window: single-port-write, registered-read memory. Entries not yet
// written since the last clear read as zero, tracked by a fill count.
// ----------------------------------------------------------------------------
module lzssd_dict
    import lzssd_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clear,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_reg;
    logic        hit_reg;
    logic [AW:0] fill_reg;

    // Writes start at entry one and advance in order, so the written span
    // is entries 1 .. fill.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_reg  <= mem[raddr];
            hit_reg <= ({1'b0, AW'(raddr - AW'(1))} < fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            fill_reg <= '0;
        end else if (we && (fill_reg != (AW+1)'(DEPTH))) begin
            fill_reg <= fill_reg + (AW+1)'(1);
        end
    end

    assign rdata = hit_reg ? rd_reg : 8'h00;

endmodule
`default_nettype wire

// ===== hdl/lzss_decoder_8k_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_decoder_8k_window
// LZSS decompressor: 8 KiB history, 13-bit absolute offsets, 4-bit lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one compressed word per handshake, bits used MSB
//   first. s_first_byte restarts the stream (history, pointers, counters);
//   s_final_byte pads the stream with zero bits until decoding stops.
//   Output channel (m_*): one decompressed or status word per handshake.
//   m_byte_valid marks data words; m_stream_done marks the single status
//   word that ends decoding (end marker or output limit). m_run_last flags
//   the last word caused by an input word.
//   cfg_we/cfg_wdata write the output limit; write it only while idle.
// Timing:
//   An input word is taken in the idle state, its 8 bits are walked one per
//   cycle while a new output word can be made, then the flush state closes
//   it. Each byte copied from the history takes a memory read state, then an
//   emit and write-back state; a final word adds up to 64 padding bits. The
//   registered read of the history memory sets the copy rate.
// Reset and stall:
//   Reset empties the history logically (no clearing pass) and sets the
//   limit to 2^29. A stalled receiver holds the block once its output
//   register and one staging word are full; nothing is dropped.
// ----------------------------------------------------------------------------
module lzss_decoder_8k_window
    import lzssd_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_in_byte,
    input  wire logic               s_first_byte,
    input  wire logic               s_final_byte,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [7:0]         m_out_byte,
    output logic                    m_byte_valid,
    output logic                    m_run_last,
    output logic                    m_stream_done
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    // Sequencer state
    state_t               state_reg, state_next;
    logic [7:0]           byte_reg, byte_next;
    logic [3:0]           left_reg, left_next;
    logic                 final_reg, final_next;
    logic [GUARD_W-1:0]   guard_reg, guard_next;
    logic                 finished_reg, finished_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [LIMIT_W-1:0]   emitted_reg, emitted_next;
    logic [LIMIT_W-1:0]   out_limit_reg;
    logic [AW-1:0]        caddr_reg, caddr_next;
    logic [RUN_W-1:0]     cleft_reg, cleft_next;

    // Staging word and output register
    logic                 pend_valid_reg;
    logic [7:0]           pend_byte_reg;
    logic                 pend_bvalid_reg;
    logic                 pend_done_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_byte_reg;
    logic                 m_bvalid_reg;
    logic                 m_last_reg;
    logic                 m_done_reg;

    // Control
    logic                 out_free, can_gen, over_limit, bits_done, cur_bit;
    logic                 gen, gen_bvalid, gen_done, flush, load_out;
    logic [7:0]           gen_byte;
    logic                 restart, tok_push, tok_clear;
    logic                 dict_we, dict_re;
    logic [7:0]           dict_rdata;
    tok_evt_t             tok_evt;

    lzssd_token u_token (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (tok_clear),
        .push    (tok_push),
        .bit_in  (cur_bit),
        .evt     (tok_evt)
    );

    lzssd_dict #(
        .DEPTH (WINDOW_DEPTH)
    ) u_dict (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (restart),
        .we      (dict_we),
        .waddr   (wp_reg),
        .wdata   (gen_byte),
        .re      (dict_re),
        .raddr   (caddr_reg),
        .rdata   (dict_rdata)
    );

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        // A new word may be made when the staging slot is empty or drains now
        can_gen    = !pend_valid_reg || out_free;
        over_limit = (emitted_reg >= out_limit_reg);
        cur_bit    = (left_reg != '0) ? byte_reg[7] : 1'b0;
        bits_done  = (left_reg == '0)
                     && (!final_reg || (guard_reg == GUARD_W'(GUARD_BITS)));

        state_next    = state_reg;
        byte_next     = byte_reg;
        left_next     = left_reg;
        final_next    = final_reg;
        guard_next    = guard_reg;
        finished_next = finished_reg;
        wp_next       = wp_reg;
        emitted_next  = emitted_reg;
        caddr_next    = caddr_reg;
        cleft_next    = cleft_reg;

        s_ready    = 1'b0;
        gen        = 1'b0;
        gen_byte   = 8'h00;
        gen_bvalid = 1'b0;
        gen_done   = 1'b0;
        flush      = 1'b0;
        restart    = 1'b0;
        tok_push   = 1'b0;
        tok_clear  = 1'b0;
        dict_we    = 1'b0;
        dict_re    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_first_byte) begin
                        restart       = 1'b1;
                        tok_clear     = 1'b1;
                        wp_next       = AW'(1);
                        emitted_next  = '0;
                        finished_next = 1'b0;
                    end
                    // Drop words that arrive after the stream has ended
                    if (s_first_byte || !finished_reg) begin
                        byte_next  = s_in_byte;
                        left_next  = 4'd8;
                        final_next = s_final_byte;
                        guard_next = '0;
                        state_next = ST_BIT;
                    end
                end
            end

            ST_BIT: begin
                if (finished_reg || bits_done) begin
                    state_next = ST_FLUSH;
                end else if (can_gen) begin
                    tok_push = 1'b1;
                    if (left_reg != '0) begin
                        byte_next = {byte_reg[6:0], 1'b0};
                        left_next = left_reg - 4'd1;
                    end else begin
                        guard_next = guard_reg + GUARD_W'(1);
                    end
                    if (tok_evt.literal) begin
                        gen = 1'b1;
                        if (over_limit) begin
                            gen_done      = 1'b1;
                            finished_next = 1'b1;
                            tok_clear     = 1'b1;
                        end else begin
                            gen_byte     = tok_evt.lit_val;
                            gen_bvalid   = 1'b1;
                            dict_we      = 1'b1;
                            wp_next      = wp_reg + AW'(1);
                            emitted_next = emitted_reg + LIMIT_W'(1);
                        end
                    end
                    if (tok_evt.end_mark) begin
                        gen           = 1'b1;
                        gen_done      = 1'b1;
                        finished_next = 1'b1;
                        tok_clear     = 1'b1;
                    end
                    if (tok_evt.match) begin
                        caddr_next = AW'(tok_evt.ofs);
                        cleft_next = tok_evt.len;
                        state_next = ST_RD;
                    end
                end
            end

            ST_RD: begin
                // Read the source byte before this step's write
                dict_re    = 1'b1;
                state_next = ST_CPY;
            end

            ST_CPY: begin
                if (can_gen) begin
                    gen = 1'b1;
                    if (over_limit) begin
                        gen_done      = 1'b1;
                        finished_next = 1'b1;
                        tok_clear     = 1'b1;
                        state_next    = ST_BIT;
                    end else begin
                        gen_byte     = dict_rdata;
                        gen_bvalid   = 1'b1;
                        dict_we      = 1'b1;
                        wp_next      = wp_reg + AW'(1);
                        emitted_next = emitted_reg + LIMIT_W'(1);
                        caddr_next   = caddr_reg + AW'(1);
                        cleft_next   = cleft_reg - RUN_W'(1);
                        state_next   = (cleft_reg == RUN_W'(1)) ? ST_BIT : ST_RD;
                    end
                end
            end

            ST_FLUSH: begin
                // Release the held word flagged as last of this input word
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        load_out = (gen && pend_valid_reg) || flush;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            final_reg     <= 1'b0;
            guard_reg     <= '0;
            finished_reg  <= 1'b0;
            wp_reg        <= AW'(1);
            emitted_reg   <= '0;
            out_limit_reg <= OUT_LIMIT_RST;
            cleft_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            left_reg     <= left_next;
            final_reg    <= final_next;
            guard_reg    <= guard_next;
            finished_reg <= finished_next;
            wp_reg       <= wp_next;
            emitted_reg  <= emitted_next;
            cleft_reg    <= cleft_next;
            if (cfg_we) begin
                out_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        caddr_reg <= caddr_next;
    end

    // Hold each new word one step back until it is known whether it is last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= load_out || (m_valid_reg && !m_ready);
            if (gen) begin
                pend_valid_reg <= 1'b1;
            end else if (flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_byte_reg   <= pend_byte_reg;
            m_bvalid_reg <= pend_bvalid_reg;
            m_done_reg   <= pend_done_reg;
            m_last_reg   <= flush;
        end
        if (gen) begin
            pend_byte_reg   <= gen_byte;
            pend_bvalid_reg <= gen_bvalid;
            pend_done_reg   <= gen_done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_byte_valid  = m_bvalid_reg;
    assign m_run_last    = m_last_reg;
    assign m_stream_done = m_done_reg;

endmodule
`default_nettype wire

// ===== tb/lzssd_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_check
// Watches both channels of the LZSS decoder, decodes every accepted input
// word on its own copy of the history and counters, and compares each output
// word field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module lzssd_check
    import lzssd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_first_byte,
    input  logic               s_final_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_out_byte,
    input  logic               m_byte_valid,
    input  logic               m_run_last,
    input  logic               m_stream_done,
    output int                 fail_count,
    output int                 words_due
);

    localparam int DEPTH = WINDOW_DEPTH_DEF;

    typedef struct packed {
        logic [7:0] data;
        logic       is_data;
        logic       last;
        logic       done;
    } out_word_t;

    logic [7:0]         history [DEPTH];
    logic [OFS_W-1:0]   wr_ptr;
    logic [TOK_W-1:0]   tok;
    logic [CNT_W-1:0]   tok_cnt;
    logic [LIMIT_W-1:0] produced;
    logic [LIMIT_W-1:0] limit;
    logic               stopped;
    out_word_t          word_batch[$];
    out_word_t          out_words_due[$];
    out_word_t          want;

    initial begin
        fail_count = 0;
        words_due  = 0;
    end

    function automatic void clear_stream();
        foreach (history[i]) history[i] = 8'h00;
        wr_ptr   = OFS_W'(1);
        tok      = '0;
        tok_cnt  = '0;
        produced = '0;
        stopped  = 1'b0;
    endfunction

    function automatic void stop_stream();
        stopped = 1'b1;
        tok     = '0;
        tok_cnt = '0;
        word_batch.push_back('{data: 8'h00, is_data: 1'b0, last: 1'b0, done: 1'b1});
    endfunction

    // Returns 0 when the output limit ends decoding instead.
    function automatic bit emit_byte(logic [7:0] v);
        if (produced >= limit) begin
            stop_stream();
            return 1'b0;
        end
        word_batch.push_back('{data: v, is_data: 1'b1, last: 1'b0, done: 1'b0});
        history[wr_ptr] = v;
        wr_ptr   = wr_ptr + 1'b1;
        produced = produced + 1'b1;
        return 1'b1;
    endfunction

    function automatic void shift_bit(logic b);
        logic [7:0]       lit;
        logic [OFS_W-1:0] ofs;
        logic [RUN_W-1:0] len;
        if (stopped) return;
        tok     = {tok[TOK_W-2:0], b};
        tok_cnt = tok_cnt + 1'b1;
        if (tok[tok_cnt - 1'b1]) begin
            if (tok_cnt == CNT_W'(LIT_BITS)) begin
                lit     = tok[7:0];
                tok     = '0;
                tok_cnt = '0;
                void'(emit_byte(lit));
            end
            return;
        end
        if (tok_cnt == CNT_W'(END_BITS)) begin
            if (tok[OFS_W-1:0] == '0) stop_stream();
            return;
        end
        if (tok_cnt == CNT_W'(MATCH_BITS)) begin
            ofs     = tok[LEN_W +: OFS_W];
            len     = RUN_W'(tok[LEN_W-1:0]) + RUN_W'(LEN_BIAS);
            tok     = '0;
            tok_cnt = '0;
            // read each source byte before the write of the same step
            for (int i = 0; i < len; i++) begin
                if (!emit_byte(history[OFS_W'(ofs + i)])) return;
            end
        end
    endfunction

    function automatic void decode_word(logic [7:0] in_byte, logic restart, logic closing);
        word_batch.delete();
        if (restart) clear_stream();
        if (stopped) return;
        for (int k = 7; k >= 0; k--) shift_bit(in_byte[k]);
        if (closing) begin
            for (int g = 0; g < GUARD_BITS && !stopped; g++) shift_bit(1'b0);
        end
        if (word_batch.size() > 0) word_batch[word_batch.size() - 1].last = 1'b1;
        foreach (word_batch[i]) out_words_due.push_back(word_batch[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_stream();
            limit = OUT_LIMIT_RST;
            out_words_due.delete();
        end else begin
            if (cfg_we) limit = cfg_wdata;
            if (s_valid && s_ready) decode_word(s_in_byte, s_first_byte, s_final_byte);
            if (m_valid && m_ready) begin
                if (out_words_due.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: output word with none expected, got 0x%0h v%0b l%0b d%0b",
                             $time, m_out_byte, m_byte_valid, m_run_last, m_stream_done);
                end else begin
                    want = out_words_due.pop_front();
                    check_field("out_byte", want.data, m_out_byte);
                    check_field("byte_valid", 8'(want.is_data), 8'(m_byte_valid));
                    check_field("run_last", 8'(want.last), 8'(m_run_last));
                    check_field("stream_done", 8'(want.done), 8'(m_stream_done));
                end
            end
        end
        words_due = out_words_due.size();
    end

endmodule

// ===== tb/tb_lzss_decoder_8k_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_decoder_8k_window
// Feeds the LZSS decoder with compressed streams built token by token
// (literals, copies, end markers), a little noise, and several output
// limits; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_lzss_decoder_8k_window
    import lzssd_pkg::*;
();

    localparam int RANDOM_WORDS  = 320;
    localparam int HOLD_AFTER    = 110;   // words sent before the long receiver hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;   // a word still walking its bits or padding
    localparam int OFS_TOP       = (1 << OFS_W) - 1;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_in_byte;
    logic               s_first_byte;
    logic               s_final_byte;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_out_byte;
    logic               m_byte_valid;
    logic               m_run_last;
    logic               m_stream_done;

    int fail_count;
    int words_due;
    int words_sent;
    int burst_left;

    // Stream builder: token bits in order, plus a rough copy of the write
    // pointer so that copies mostly point at bytes already written.
    bit               stream_bits[$];
    logic [OFS_W-1:0] gen_wp;
    int               gen_made;

    lzss_decoder_8k_window dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_first_byte  (s_first_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_run_last    (m_run_last),
        .m_stream_done (m_stream_done)
    );

    lzssd_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_first_byte  (s_first_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_run_last    (m_run_last),
        .m_stream_done (m_stream_done),
        .fail_count    (fail_count),
        .words_due     (words_due)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #15_000_000;
        $display("FAIL lzss_decoder_8k_window");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    function automatic void gen_restart();
        gen_wp   = OFS_W'(1);
        gen_made = 0;
        stream_bits.delete();
    endfunction

    function automatic void add_bits(logic [TOK_W-1:0] v, int width);
        for (int k = width - 1; k >= 0; k--) stream_bits.push_back(v[k]);
    endfunction

    function automatic void add_literal(logic [7:0] v);
        add_bits({1'b1, v}, LIT_BITS);
        gen_wp = gen_wp + 1'b1;
        gen_made++;
    endfunction

    function automatic void add_match(logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] len);
        add_bits({1'b0, ofs, len}, MATCH_BITS);
        gen_wp   = gen_wp + OFS_W'(len + LEN_BIAS);
        gen_made = gen_made + len + LEN_BIAS;
    endfunction

    function automatic void add_end();
        add_bits('0, END_BITS);
    endfunction

    // Mostly reach back into the recent output; sometimes anywhere, or the
    // top of the window so the copy wraps to index 0.
    function automatic logic [OFS_W-1:0] pick_offset();
        logic [OFS_W-1:0] ofs;
        int               reach;
        reach = (gen_made < 40) ? gen_made : 40;
        case ($urandom_range(0, 9))
            0, 1:    ofs = OFS_W'($urandom_range(1, OFS_TOP));
            2:       ofs = OFS_W'($urandom_range(OFS_TOP - 15, OFS_TOP));
            default: begin
                if (reach == 0) ofs = OFS_W'($urandom_range(1, OFS_TOP));
                else ofs = gen_wp - OFS_W'($urandom_range(1, reach));
            end
        endcase
        if (ofs == '0) ofs = OFS_W'(1);   // keep it a copy, not an end marker
        return ofs;
    endfunction

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------
    // Offer one word; idle between bursts of random length.
    task automatic send_word(logic [7:0] data, logic restart, logic closing);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_in_byte    <= data;
        s_first_byte <= restart;
        s_final_byte <= closing;
        // hold the word until it is taken
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Pack the built bits into words, padding the tail with random bits.
    task automatic ship_stream(logic restart, logic closing);
        logic [7:0] data;
        int         n_words;
        if (stream_bits.size() == 0) add_bits(TOK_W'($urandom_range(0, 255)), 8);
        while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
        n_words = stream_bits.size() / 8;
        for (int w = 0; w < n_words; w++) begin
            for (int k = 0; k < 8; k++) data = {data[6:0], stream_bits.pop_front()};
            send_word(data, restart && (w == 0), closing && (w == n_words - 1));
        end
    endtask

    task automatic random_stream();
        logic restart;
        logic closing;
        int   n_tok;
        restart = ($urandom_range(0, 4) != 0);
        if (restart) gen_restart();
        n_tok = $urandom_range(1, 14);
        repeat (n_tok) begin
            if ($urandom_range(0, 1)) add_literal(8'($urandom_range(0, 255)));
            else add_match(pick_offset(), LEN_W'($urandom_range(0, 15)));
        end
        closing = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1)) add_end();
        ship_stream(restart, closing);
    endtask

    // Raw words with random flags: broken streams and restarts mid-token.
    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0);
        end
        gen_made = 0;
        stream_bits.delete();
    endtask

    // Drop valid, wait for every expected word, then let the block go quiet.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output channel: stall on shifting patterns, plus one long hold-off
    // while the sender keeps offering words, so the block backs up.
    // ------------------------------------------------------------------
    initial begin : rx_stall
        int       hold_left;
        int       tick;
        bit       hold_taken;
        rx_mode_t mode;
        hold_left  = 0;
        tick       = 0;
        hold_taken = 1'b0;
        mode       = RX_OPEN;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_taken && words_sent >= HOLD_AFTER) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (tick % 48 == 0) mode = rx_mode_t'($urandom_range(0, 3));
                tick++;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase_goal;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_in_byte    = 8'h00;
        s_first_byte = 1'b0;
        s_final_byte = 1'b0;
        words_sent   = 0;
        burst_left   = 0;
        gen_restart();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_limit(OUT_LIMIT_RST);

        // Literals at both ends of the byte range, a copy that overlaps the
        // bytes it writes, a copy that wraps past the top of the window,
        // then an explicit end marker.
        gen_restart();
        add_literal(8'h00);
        add_literal(8'hFF);
        add_literal(8'hA5);
        add_match(OFS_W'(1), 4'hF);
        add_match(OFS_W'(OFS_TOP), 4'hF);
        add_end();
        ship_stream(1'b1, 1'b1);

        // Decoding has stopped: these are dropped without a restart.
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);

        // Final word lands mid-literal; padding finishes it and ends the stream.
        gen_restart();
        add_literal(8'h3C);
        add_bits(TOK_W'(5'b10101), 5);
        ship_stream(1'b1, 1'b1);

        // Restart and final on the same word.
        send_word(8'h80, 1'b1, 1'b1);

        // Leave a stream open, lower the limit under what is already out,
        // then continue: the next byte out ends decoding.
        gen_restart();
        add_literal(8'h5A);
        add_literal(8'hC3);
        ship_stream(1'b1, 1'b0);
        write_limit(LIMIT_W'(1));
        add_literal(8'h11);
        add_literal(8'h22);
        ship_stream(1'b0, 1'b1);

        // Limit of zero: the very first literal is dropped.
        write_limit('0);
        gen_restart();
        add_literal(8'h77);
        ship_stream(1'b1, 1'b1);

        // Limit reached in the middle of a copy.
        write_limit(LIMIT_W'(7));
        gen_restart();
        add_literal(8'h9E);
        add_match(OFS_W'(1), 4'hF);
        ship_stream(1'b1, 1'b1);

        // Random streams in four phases, each under its own limit.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       write_limit(OUT_LIMIT_RST);
                1:       write_limit(LIMIT_W'($urandom_range(1, 60)));
                2:       write_limit(LIMIT_W'($urandom_range(100, 4000)));
                default: write_limit(OUT_LIMIT_RST);
            endcase
            phase_goal = words_sent + RANDOM_WORDS / 4;
            while (words_sent < phase_goal) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else random_stream();
            end
        end

        settle();
        if (fail_count == 0 && words_due == 0) begin
            $display("PASS lzss_decoder_8k_window");
        end else begin
            $display("FAIL lzss_decoder_8k_window");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lzssd_pkg.sv
hdl/lzssd_token.sv
hdl/lzssd_dict.sv
hdl/lzss_decoder_8k_window.sv
tb/lzssd_check.sv
tb/tb_lzss_decoder_8k_window.sv
